FILE: hw/rtl/sfdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants and types for the deframer with additive checksum.
// ----------------------------------------------------------------------------
package sfdc_pkg;

    // Default largest payload length accepted in one frame.
    localparam int MAX_PAYLOAD_DEF = 32;

    // Byte width of the serial stream and of the frame store.
    localparam int BYTE_W = 8;

    // Header byte value after reset.
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h55;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_GOOD    = 2'd0,
        STATUS_SUM_ERR = 2'd1,
        STATUS_LEN_ERR = 2'd2
    } t_status;

endpackage

FILE: hw/rtl/sfdc_frame_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame store memory
// Single write port and single read port; read data is registered and holds
// its value until the next read.
// ----------------------------------------------------------------------------
module sfdc_frame_mem
    import sfdc_pkg::*;
#(
    parameter int DEPTH = MAX_PAYLOAD_DEF + 1,
    parameter int AW    = $clog2(MAX_PAYLOAD_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [BYTE_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sfdc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer control
// Parses header, function, length, payload and checksum bytes, drives the
// frame store, loads an error result for a bad length or checksum, and plays
// a good frame back from the store into the result register.
// ----------------------------------------------------------------------------
module sfdc_ctrl
    import sfdc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int AW          = $clog2(MAX_PAYLOAD_DEF + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_header_value,
    // Incoming byte channel.
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // Frame store port.
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_waddr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    output logic              o_mem_re,
    output logic [AW-1:0]     o_mem_raddr,
    input  logic [BYTE_W-1:0] i_mem_rdata,
    // Result channel.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_is_function,
    output logic              o_out_last,
    output t_status           o_out_status
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_FUNC,
        ST_LEN,
        ST_DATA,
        ST_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_count, n_count;
    logic [AW-1:0]     r_len, n_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [AW-1:0]     r_rd_addr, n_rd_addr;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_out_byte, n_out_byte;
    logic              r_out_is_function, n_out_is_function;
    logic              r_out_last, n_out_last;
    t_status           r_out_status, n_out_status;

    logic              out_free;
    logic              rx_fire;

    // The result register can take a new result when empty or being drained.
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_rx_ready = (r_state != ST_EMIT) && out_free;
    assign rx_fire    = i_rx_valid && o_rx_ready;

    // Next-state, store access and result loading.
    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_len             = r_len;
        n_sum             = r_sum;
        n_rd_addr         = r_rd_addr;
        n_out_valid       = r_out_valid;
        n_out_byte        = r_out_byte;
        n_out_is_function = r_out_is_function;
        n_out_last        = r_out_last;
        n_out_status      = r_out_status;

        o_mem_we    = 1'b0;
        o_mem_waddr = r_count + AW'(1);
        o_mem_wdata = i_rx_byte;
        o_mem_re    = 1'b0;
        o_mem_raddr = r_rd_addr + AW'(1);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_HUNT: begin
                if (rx_fire && (i_rx_byte == i_header_value)) begin
                    n_state = ST_FUNC;
                end
            end
            ST_FUNC: begin
                // Function code goes to entry zero and seeds the sum.
                if (rx_fire) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = '0;
                    n_sum       = i_rx_byte;
                    n_count     = '0;
                    n_state     = ST_LEN;
                end
            end
            ST_LEN: begin
                if (rx_fire) begin
                    if (i_rx_byte > BYTE_W'(MAX_PAYLOAD)) begin
                        n_out_valid       = 1'b1;
                        n_out_byte        = '0;
                        n_out_is_function = 1'b0;
                        n_out_last        = 1'b1;
                        n_out_status      = STATUS_LEN_ERR;
                        n_sum             = '0;
                        n_len             = '0;
                        n_state           = ST_HUNT;
                    end else begin
                        n_len   = i_rx_byte[AW-1:0];
                        n_sum   = r_sum + i_rx_byte;
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (rx_fire) begin
                    if (r_count < r_len) begin
                        // Payload byte: store it and add it to the sum.
                        o_mem_we = 1'b1;
                        n_sum    = r_sum + i_rx_byte;
                        n_count  = r_count + AW'(1);
                    end else if (i_rx_byte != r_sum) begin
                        // Checksum mismatch.
                        n_out_valid       = 1'b1;
                        n_out_byte        = '0;
                        n_out_is_function = 1'b0;
                        n_out_last        = 1'b1;
                        n_out_status      = STATUS_SUM_ERR;
                        n_sum             = '0;
                        n_len             = '0;
                        n_state           = ST_HUNT;
                    end else begin
                        // Good frame: fetch the function code first.
                        o_mem_re    = 1'b1;
                        o_mem_raddr = '0;
                        n_rd_addr   = '0;
                        n_state     = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                // One stored byte per free slot, prefetching the next entry.
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out_byte        = i_mem_rdata;
                    n_out_is_function = (r_rd_addr == '0);
                    n_out_last        = (r_rd_addr == r_len);
                    n_out_status      = STATUS_GOOD;
                    if (r_rd_addr == r_len) begin
                        n_sum   = '0;
                        n_len   = '0;
                        n_state = ST_HUNT;
                    end else begin
                        o_mem_re  = 1'b1;
                        n_rd_addr = r_rd_addr + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_count     <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
        r_rd_addr         <= n_rd_addr;
        r_out_byte        <= n_out_byte;
        r_out_is_function <= n_out_is_function;
        r_out_last        <= n_out_last;
        r_out_status      <= n_out_status;
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_byte        = r_out_byte;
    assign o_out_is_function = r_out_is_function;
    assign o_out_last        = r_out_last;
    assign o_out_status      = r_out_status;

endmodule

FILE: hw/rtl/serial_frame_deframer_checksum_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial frame deframer with checksum
// Finds frames of header, function, length, payload and an 8-bit additive
// checksum in a byte stream and emits checked frames as result runs.
// ----------------------------------------------------------------------------
// The block takes one received byte per cycle while its result register is
// free. Header hunting, the function, length and payload bytes produce no
// result; a length above MAX_PAYLOAD or a wrong checksum produces one error
// result at once. A good checksum starts playback of the frame store: the
// first result passes through the memory read register and then the result
// register; after that, one result per cycle while the result register is
// free, for L+1 results, and no byte is accepted until the last one is
// loaded. The pace of playback is set by the single read port of the frame
// store and by the result register being free. The header register may be
// written at any idle time and takes effect at the next hunt.
module serial_frame_deframer_checksum_top
    import sfdc_pkg::*;
#(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Header register write.
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_data,
    // Incoming bytes.
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [BYTE_W-1:0] i_rx_byte,
    // Results.
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic              o_out_is_function,
    output logic              o_out_last,
    output logic [1:0]        o_out_status
);

    localparam int DEPTH = MAX_PAYLOAD + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [BYTE_W-1:0] r_header_value;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    t_status           out_status;

    // Header byte register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value <= HEADER_RESET;
        end else if (i_cfg_we) begin
            r_header_value <= i_cfg_data;
        end
    end

    sfdc_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_header_value    (r_header_value),
        .i_rx_valid        (i_rx_valid),
        .o_rx_ready        (o_rx_ready),
        .i_rx_byte         (i_rx_byte),
        .o_mem_we          (mem_we),
        .o_mem_waddr       (mem_waddr),
        .o_mem_wdata       (mem_wdata),
        .o_mem_re          (mem_re),
        .o_mem_raddr       (mem_raddr),
        .i_mem_rdata       (mem_rdata),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_out_byte        (o_out_byte),
        .o_out_is_function (o_out_is_function),
        .o_out_last        (o_out_last),
        .o_out_status      (out_status)
    );

    sfdc_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_out_status = out_status;

endmodule
